@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by btsg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on the rising clock edge.
`define BTSG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen on a clock edge.
`define BTSG_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ sv/btsg_pkg.sv @@
// ----------------------------------------------------------------------------
// btsg_pkg
// Types, constants and helpers for the tag span grouper.
// ----------------------------------------------------------------------------
package btsg_pkg;

  localparam int unsigned NUM_LOGITS = 8;
  localparam int unsigned LOGIT_W    = 16;
  localparam int unsigned MAX_SEQ    = 512;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned START_W    = 9;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned SUM_W      = 26;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // register reset values and the padding id
  localparam logic [CC_W-1:0]    CLASS_COUNT_RST = 4'd3;
  localparam logic [CLASS_W-1:0] BEGIN_CLASS_RST = 3'd1;
  localparam logic [CLASS_W-1:0] INSIDE_CLASS_RST = 3'd2;
  localparam logic [ID_W-1:0]    SKIP_FIRST_RST  = 16'd101;
  localparam logic [ID_W-1:0]    SKIP_SECOND_RST = 16'd102;
  localparam logic [ID_W-1:0]    PAD_ID          = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT  = 3'd0,
    REG_BEGIN_CLASS  = 3'd1,
    REG_INSIDE_CLASS = 3'd2,
    REG_SKIP_FIRST   = 3'd3,
    REG_SKIP_SECOND  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARGMAX,
    S_TAG,
    S_DIVIDE,
    S_EMIT_SPAN,
    S_FLUSH,
    S_EMIT_DONE
  } state_t;

  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef logic signed [LOGIT_W-1:0] logit_t;

  typedef struct packed {
    logic [ID_W-1:0]           vocab_id;
    logic signed [LOGIT_W-1:0] logit_0;
    logic signed [LOGIT_W-1:0] logit_1;
    logic signed [LOGIT_W-1:0] logit_2;
    logic signed [LOGIT_W-1:0] logit_3;
    logic signed [LOGIT_W-1:0] logit_4;
    logic signed [LOGIT_W-1:0] logit_5;
    logic signed [LOGIT_W-1:0] logit_6;
    logic signed [LOGIT_W-1:0] logit_7;
    logic                      last_token;
  } tok_t;

  typedef struct packed {
    logic                    kind;
    logic [START_W-1:0]      span_start;
    logic [POS_W-1:0]        span_end;
    logic [COUNT_W-1:0]      span_tokens;
    logic signed [AVG_W-1:0] score_avg;
    logic                    last_result;
  } span_t;

  // one argmax candidate
  typedef struct packed {
    logic               valid;
    logic [CLASS_W-1:0] idx;
    logit_t             val;
  } cand_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [COUNT_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [AVG_W-1:0] quotient;
  } div_rsp_t;

  // Lower index sits in a; it keeps the win on a tie.
  function automatic cand_t cand_merge(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.valid && (b.val > a.val)) begin
      r = b;
    end
    return r;
  endfunction

endpackage

@@ sv/btsg_lane.sv @@
// ----------------------------------------------------------------------------
// btsg_lane
// One class lane: qualifies its logit against the active class count.
// ----------------------------------------------------------------------------
module btsg_lane
  import btsg_pkg::*;
(
  input  logit_t             logit,
  input  logic [CLASS_W-1:0] lane_id,
  input  logic [CC_W-1:0]    class_eff,
  output cand_t              cand
);

  always_comb begin
    cand.valid = (CC_W'(lane_id) < class_eff);
    cand.idx   = lane_id;
    cand.val   = logit;
  end

endmodule

@@ sv/btsg_argmax.sv @@
// ----------------------------------------------------------------------------
// btsg_argmax
// Class lanes side by side and a registered merge tree picking the maximum.
// ----------------------------------------------------------------------------
module btsg_argmax
  import btsg_pkg::*;
(
  input  logic            clk,
  input  logit_t          logits [NUM_LOGITS],
  input  logic [CC_W-1:0] class_count,
  output cand_t           best
);

  logic [CC_W-1:0] class_eff;
  cand_t           lane_cand [NUM_LOGITS];
  cand_t           lvl1 [NUM_LOGITS/2];
  cand_t           lvl2 [NUM_LOGITS/4];

  // out-of-range counts clamp to 2..NUM_LOGITS
  always_comb begin
    if (class_count < CC_W'(2)) begin
      class_eff = CC_W'(2);
    end else if (class_count > CC_W'(NUM_LOGITS)) begin
      class_eff = CC_W'(NUM_LOGITS);
    end else begin
      class_eff = class_count;
    end
  end

  for (genvar g = 0; g < NUM_LOGITS; g++) begin : g_lane
    btsg_lane u_lane (
      .logit     (logits[g]),
      .lane_id   (CLASS_W'(g)),
      .class_eff (class_eff),
      .cand      (lane_cand[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_LOGITS/2; i++) begin
      lvl1[i] = cand_merge(lane_cand[2*i], lane_cand[2*i+1]);
    end
    for (int i = 0; i < NUM_LOGITS/4; i++) begin
      lvl2[i] = cand_merge(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    best <= cand_merge(lvl2[0], lvl2[1]);
  end

endmodule

@@ sv/btsg_divider.sv @@
// ----------------------------------------------------------------------------
// btsg_divider
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module btsg_divider
  import btsg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [COUNT_W-1:0]  rem;
  logic [SUM_W-1:0]    quo;
  logic [COUNT_W-1:0]  divisor;
  logic                neg;
  logic [COUNT_W:0]    trial;
  logic                fits;
  logic [SUM_W-1:0]    quo_signed;

  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg     <= req.dividend[SUM_W-1];
      quo     <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quo_signed   = neg ? (~quo + SUM_W'(1)) : quo;
  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[AVG_W-1:0];

endmodule

@@ sv/bio_tag_span_grouper.sv @@
// ----------------------------------------------------------------------------
// bio_tag_span_grouper
// Groups tagged tokens into keyword spans and reports each span's extent and
// mean winning score.
// ----------------------------------------------------------------------------
// One token is taken per item. Eight class lanes and a merge tree find the
// winning class (first maximum on ties) into a register in the argmax state;
// the tag state then tags the token and updates the open span. Closing a
// span starts a serial divider for the mean score, one quotient bit per cycle.
// The item marked last_token may close two spans and then sends the done
// marker. The block takes one item at a time; a finished result sits in the
// output register while the next item is accepted.
// ----------------------------------------------------------------------------
module bio_tag_span_grouper
  import btsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // token items
  input  logic                 tok_valid,
  output logic                 tok_stall,
  input  tok_t                 tok,
  // result items
  output logic                 span_valid,
  input  logic                 span_stall,
  output span_t                span,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [CC_W-1:0]    class_count;
  logic [CLASS_W-1:0] begin_class;
  logic [CLASS_W-1:0] inside_class;
  logic [ID_W-1:0]    skip_id_first;
  logic [ID_W-1:0]    skip_id_second;

  // control
  state_t state, state_next;
  logic   flushing;

  // sequence state
  logic [POS_W-1:0]        position;
  logic                    stopped;
  logic                    phrase_open;
  logic [START_W-1:0]      phrase_start;
  logic [COUNT_W-1:0]      phrase_count;
  logic signed [SUM_W-1:0] score_sum;

  // item being worked on and the span being reported
  tok_t                    tok_reg;
  logit_t                  logits [NUM_LOGITS];
  cand_t                   best;
  logic [START_W-1:0]      sp_start;
  logic [POS_W-1:0]        sp_end;
  logic [COUNT_W-1:0]      sp_count;
  logic signed [AVG_W-1:0] sp_avg;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // decode of the current item
  logic in_range, tag_live, is_begin, is_inside, is_other;
  logic close_now, flush_close, out_free;
  // per-state strobes
  logic tag_step, flush_step, div_capture, span_load, done_load;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count    <= CLASS_COUNT_RST;
      begin_class    <= BEGIN_CLASS_RST;
      inside_class   <= INSIDE_CLASS_RST;
      skip_id_first  <= SKIP_FIRST_RST;
      skip_id_second <= SKIP_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLASS_COUNT:  class_count    <= cfg_data[CC_W-1:0];
        REG_BEGIN_CLASS:  begin_class    <= cfg_data[CLASS_W-1:0];
        REG_INSIDE_CLASS: inside_class   <= cfg_data[CLASS_W-1:0];
        REG_SKIP_FIRST:   skip_id_first  <= cfg_data[ID_W-1:0];
        REG_SKIP_SECOND:  skip_id_second <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input capture and argmax lanes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (tok_valid && !tok_stall) begin
      tok_reg <= tok;
    end
  end

  always_comb begin
    logits[0] = tok_reg.logit_0;
    logits[1] = tok_reg.logit_1;
    logits[2] = tok_reg.logit_2;
    logits[3] = tok_reg.logit_3;
    logits[4] = tok_reg.logit_4;
    logits[5] = tok_reg.logit_5;
    logits[6] = tok_reg.logit_6;
    logits[7] = tok_reg.logit_7;
  end

  btsg_argmax u_argmax (
    .clk         (clk),
    .logits      (logits),
    .class_count (class_count),
    .best        (best)
  );

  // --------------------------------------------------------------------------
  // Tag decode. The winning index is always below the clamped class count, so
  // a tag class out of reach never matches. Begin wins over inside when equal.
  // --------------------------------------------------------------------------
  always_comb begin
    in_range    = (position < POS_W'(MAX_SEQ));
    tag_live    = in_range && !stopped && (tok_reg.vocab_id != PAD_ID) &&
                  (tok_reg.vocab_id != skip_id_first) &&
                  (tok_reg.vocab_id != skip_id_second);
    is_begin    = tag_live && (best.idx == begin_class);
    is_inside   = tag_live && !is_begin && (best.idx == inside_class);
    is_other    = tag_live && !is_begin && !is_inside;
    close_now   = (is_begin || is_other) && phrase_open && (phrase_count != '0);
    flush_close = phrase_open && (phrase_count != '0);
    out_free    = !span_valid || !span_stall;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tok_valid) state_next = S_ARGMAX;
      end
      S_ARGMAX: state_next = S_TAG;
      S_TAG: begin
        if (close_now) begin
          state_next = S_DIVIDE;
        end else if (tok_reg.last_token) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (div_rsp.done) state_next = S_EMIT_SPAN;
      end
      S_EMIT_SPAN: begin
        if (out_free) begin
          if (!tok_reg.last_token) begin
            state_next = S_IDLE;
          end else if (flushing) begin
            state_next = S_EMIT_DONE;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: state_next = flush_close ? S_DIVIDE : S_EMIT_DONE;
      S_EMIT_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tok_stall   = 1'b1;
    tag_step    = 1'b0;
    flush_step  = 1'b0;
    div_capture = 1'b0;
    span_load   = 1'b0;
    done_load   = 1'b0;
    case (state)
      S_IDLE:      tok_stall   = 1'b0;
      S_TAG:       tag_step    = 1'b1;
      S_DIVIDE:    div_capture = div_rsp.done;
      S_EMIT_SPAN: span_load   = out_free;
      S_FLUSH:     flush_step  = 1'b1;
      S_EMIT_DONE: done_load   = out_free;
      default: ;
    endcase
  end

  // divider samples the span state on the same edge that clears or reopens it
  assign div_req.start    = (tag_step && close_now) || (flush_step && flush_close);
  assign div_req.dividend = score_sum;
  assign div_req.divisor  = phrase_count;

  btsg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequence state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || done_load) begin
      position     <= '0;
      stopped      <= 1'b0;
      phrase_open  <= 1'b0;
      phrase_start <= '0;
      phrase_count <= '0;
      score_sum    <= '0;
    end else if (tag_step) begin
      if (in_range) begin
        position <= position + POS_W'(1);
      end
      if (in_range && !stopped && (tok_reg.vocab_id == PAD_ID)) begin
        stopped <= 1'b1;
      end
      if (is_begin || (is_inside && !phrase_open)) begin
        phrase_open  <= 1'b1;
        phrase_start <= position[START_W-1:0];
        phrase_count <= COUNT_W'(1);
        score_sum    <= SUM_W'(best.val);
      end else if (is_inside) begin
        phrase_count <= phrase_count + COUNT_W'(1);
        score_sum    <= score_sum + SUM_W'(best.val);
      end else if (close_now) begin
        phrase_open  <= 1'b0;
        phrase_count <= '0;
        score_sum    <= '0;
      end
    end else if (flush_step && flush_close) begin
      phrase_open  <= 1'b0;
      phrase_count <= '0;
      score_sum    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
    end else if (flush_step) begin
      flushing <= 1'b1;
    end else if (done_load) begin
      flushing <= 1'b0;
    end
  end

  // span being closed: end is the token index while tagging, length at flush
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      sp_start <= phrase_start;
      sp_end   <= position;
      sp_count <= phrase_count;
    end
    if (div_capture) begin
      sp_avg <= div_rsp.quotient;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (span_load || done_load) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (span_load) begin
      span.kind        <= KIND_SPAN;
      span.span_start  <= sp_start;
      span.span_end    <= sp_end;
      span.span_tokens <= sp_count;
      span.score_avg   <= sp_avg;
      // on the last item the done marker follows
      span.last_result <= !tok_reg.last_token;
    end else if (done_load) begin
      span.kind        <= KIND_DONE;
      span.span_start  <= '0;
      span.span_end    <= position;
      span.span_tokens <= '0;
      span.score_avg   <= '0;
      span.last_result <= 1'b1;
    end
  end

endmodule

@@ sv/btsg_checker.sv @@
// ----------------------------------------------------------------------------
// btsg_checker
// Port-level checks for the tag span grouper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btsg_checker
  import btsg_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  tok_valid,
  input logic  tok_stall,
  input tok_t  tok,
  input logic  span_valid,
  input logic  span_stall,
  input span_t span
);

  logic span_held;
  logic tok_held;
  logic tok_taken;
  logic is_span;
  logic shape_ok;
  logic done_not_last;

  assign span_held     = span_valid && span_stall;
  assign tok_held      = tok_valid && tok_stall;
  assign tok_taken     = tok_valid && !tok_stall;
  assign is_span       = span_valid && (span.kind == KIND_SPAN);
  assign shape_ok      = (span.span_tokens != '0) &&
                         (span.span_end > {1'b0, span.span_start});
  assign done_not_last = span_valid && (span.kind == KIND_DONE) && !span.last_result;

  `BTSG_ASSERT(a_span_hold, clk, rst, span_held |=> span_valid && $stable(span), "span moved")
  `BTSG_ASSERT(a_busy_after_take, clk, rst, tok_taken |=> tok_stall, "no stall after take")
  `BTSG_ASSERT(a_span_shape, clk, rst, is_span |-> shape_ok, "empty or inverted span")
  `BTSG_NEVER(a_done_is_last, clk, rst, done_not_last, "done marker not flagged last")
  `BTSG_ASSERT(a_tok_hold, clk, rst, tok_held |=> tok_valid && $stable(tok), "token moved")

endmodule

bind bio_tag_span_grouper btsg_checker u_checker (.*);

@@ tb/sv/span_checker.sv @@
// ----------------------------------------------------------------------------
// span_checker
// Watches the token, span and register ports of the tag span grouper, keeps
// its own copy of the span state and registers, and checks each span item
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module span_checker
  import btsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tok_valid,
  input  logic                 tok_stall,
  input  tok_t                 tok,
  input  logic                 span_valid,
  input  logic                 span_stall,
  input  span_t                span,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int unsigned          pending,
  output int unsigned          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  // register copies
  logic [CC_W-1:0]    cls_count;
  logic [CLASS_W-1:0] begin_cls;
  logic [CLASS_W-1:0] inside_cls;
  logic [ID_W-1:0]    skip_first;
  logic [ID_W-1:0]    skip_second;

  // sequence and open phrase
  int     seq_pos;
  bit     seq_stopped;
  bit     phrase_open;
  int     phrase_start;
  int     phrase_count;
  longint phrase_sum;

  span_t step_spans[$];
  span_t expected_spans[$];

  function automatic void clear_sequence();
    seq_pos      = 0;
    seq_stopped  = 1'b0;
    phrase_open  = 1'b0;
    phrase_start = 0;
    phrase_count = 0;
    phrase_sum   = 0;
  endfunction

  function automatic void open_phrase(int pos, longint score);
    phrase_open  = 1'b1;
    phrase_start = pos;
    phrase_count = 1;
    phrase_sum   = score;
  endfunction

  function automatic void close_phrase(int end_pos);
    span_t s;
    if (!phrase_open || phrase_count == 0) return;
    s.kind        = KIND_SPAN;
    s.span_start  = START_W'(phrase_start);
    s.span_end    = POS_W'(end_pos);
    s.span_tokens = COUNT_W'(phrase_count);
    s.score_avg   = AVG_W'(phrase_sum / phrase_count); // truncates toward zero
    s.last_result = 1'b0;
    step_spans.insert(step_spans.size(), s);
    phrase_open  = 1'b0;
    phrase_count = 0;
    phrase_sum   = 0;
  endfunction

  function automatic void predict_token(tok_t t);
    logit_t lg [NUM_LOGITS];
    int     n;
    int     best;
    logit_t best_val;
    span_t  done_mark;
    lg = '{t.logit_0, t.logit_1, t.logit_2, t.logit_3,
           t.logit_4, t.logit_5, t.logit_6, t.logit_7};
    step_spans.delete();
    if (seq_pos < MAX_SEQ) begin
      if (!seq_stopped) begin
        if (t.vocab_id == PAD_ID) begin
          seq_stopped = 1'b1;
        end else if (t.vocab_id != skip_first && t.vocab_id != skip_second) begin
          n = int'(cls_count);
          if (n < 2) n = 2;
          if (n > NUM_LOGITS) n = NUM_LOGITS;
          best     = 0;
          best_val = lg[0];
          for (int c = 1; c < n; c++) begin
            if (lg[c] > best_val) begin
              best_val = lg[c];
              best     = c;
            end
          end
          // begin is tested first, so it wins when both classes are equal
          if (best == int'(begin_cls)) begin
            close_phrase(seq_pos);
            open_phrase(seq_pos, best_val);
          end else if (best == int'(inside_cls)) begin
            if (phrase_open) begin
              phrase_count++;
              phrase_sum += best_val;
            end else begin
              open_phrase(seq_pos, best_val);
            end
          end else begin
            close_phrase(seq_pos);
          end
        end
      end
      seq_pos++;
    end
    if (t.last_token) begin
      close_phrase(seq_pos);
      done_mark             = '0;
      done_mark.kind        = KIND_DONE;
      done_mark.span_end    = POS_W'(seq_pos);
      step_spans.insert(step_spans.size(), done_mark);
      clear_sequence();
    end
    if (step_spans.size() > 0) step_spans[$].last_result = 1'b1;
    foreach (step_spans[k]) expected_spans.insert(expected_spans.size(), step_spans[k]);
  endfunction

  function automatic string span_text(span_t s);
    return $sformatf("kind=%0d start=%0d end=%0d tokens=%0d avg=%0d last=%0d",
                     s.kind, s.span_start, s.span_end, s.span_tokens,
                     $signed(s.score_avg), s.last_result);
  endfunction

  function automatic void check_span(span_t got);
    span_t want;
    if (expected_spans.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected span item: %s", $realtime, span_text(got));
      return;
    end
    want = expected_spans.pop_front();
    if (got.kind !== want.kind || got.span_start !== want.span_start ||
        got.span_end !== want.span_end || got.span_tokens !== want.span_tokens ||
        got.score_avg !== want.score_avg || got.last_result !== want.last_result) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: span mismatch", $realtime);
        $display("  expected %s", span_text(want));
        $display("  actual   %s", span_text(got));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cls_count   = CLASS_COUNT_RST;
      begin_cls   = BEGIN_CLASS_RST;
      inside_cls  = INSIDE_CLASS_RST;
      skip_first  = SKIP_FIRST_RST;
      skip_second = SKIP_SECOND_RST;
      errors      = 0;
      clear_sequence();
      expected_spans.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLASS_COUNT:  cls_count   = cfg_data[CC_W-1:0];
          REG_BEGIN_CLASS:  begin_cls   = cfg_data[CLASS_W-1:0];
          REG_INSIDE_CLASS: inside_cls  = cfg_data[CLASS_W-1:0];
          REG_SKIP_FIRST:   skip_first  = cfg_data[ID_W-1:0];
          REG_SKIP_SECOND:  skip_second = cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
      // results go first: a token never yields a span on its own accept edge
      if (span_valid && !span_stall) check_span(span);
      if (tok_valid && !tok_stall) predict_token(tok);
    end
    pending = expected_spans.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives token items into the tag span grouper and judges the span items.
// ----------------------------------------------------------------------------
// A directed run covers score extremes, argmax ties, skip and padding ids,
// stop, inside-without-begin and the three-result flush. Random sequences
// then run under three idle profiles and a spread of register settings,
// including out-of-range class counts, unreachable tag classes and begin
// equal to inside. Checking is done by span_checker.
// ----------------------------------------------------------------------------
module testbench;
  import btsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Settle time beyond the worst item in the block.
  localparam int SETTLE_CYCLES = 80;
  // ~210 items, each up to 3 results under heavy stalls, taken several times
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int BLOCK_ITEMS   = 12;

  logic                 clk;
  logic                 rst;
  logic                 tok_valid;
  logic                 tok_stall;
  tok_t                 tok;
  logic                 span_valid;
  logic                 span_stall;
  span_t                span;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned pending_spans;
  int unsigned check_errors;
  int          cycle_count;

  // idle profile, percent of cycles
  int src_idle_pct;
  int sink_stall_pct;

  // register values as last written; only used to shape the stimulus
  int cfg_count;
  int cfg_begin;
  int cfg_inside;
  logic [ID_W-1:0] cfg_skip1;
  logic [ID_W-1:0] cfg_skip2;

  bio_tag_span_grouper u_dut (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok        (tok),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  span_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok        (tok),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending_spans),
    .errors     (check_errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall decided fresh at every falling edge.
  initial begin
    span_stall = 1'b0;
    forever begin
      @(negedge clk);
      span_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int eff_count();
    if (cfg_count < 2) return 2;
    if (cfg_count > NUM_LOGITS) return NUM_LOGITS;
    return cfg_count;
  endfunction

  // Bias toward the tag classes so that spans actually form.
  function automatic int pick_class();
    int n;
    int r;
    int c;
    n = eff_count();
    r = $urandom_range(99);
    if (r < 40) c = cfg_inside;
    else if (r < 65) c = cfg_begin;
    else c = $urandom_range(n - 1);
    if (c >= n) c = $urandom_range(n - 1);
    return c;
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit may_stop);
    int r;
    r = $urandom_range(99);
    if (r < 4 && may_stop) return PAD_ID;
    if (r < 10) return cfg_skip1;
    if (r < 16) return cfg_skip2;
    return ID_W'($urandom_range(65535, 1));
  endfunction

  // Logits that make class cls the argmax over the live classes. Lower
  // classes stay strictly below the winner, higher ones may tie it (the
  // first maximum must still win). Dead lanes get anything.
  function automatic tok_t make_token(int cls, logic [ID_W-1:0] id, bit last);
    tok_t t;
    int   lg [NUM_LOGITS];
    int   n;
    int   w;
    int   lo;
    n  = eff_count();
    lo = -32768;
    w  = int'($urandom_range(65535)) + lo;
    if (cls != 0 && w == lo) w = lo + 1;
    for (int j = 0; j < NUM_LOGITS; j++) begin
      if (j >= n) lg[j] = int'($urandom_range(65535)) + lo;
      else if (j == cls) lg[j] = w;
      else if (j < cls) lg[j] = lo + int'($urandom_range(w - lo - 1));
      else if ($urandom_range(3) == 0) lg[j] = w;
      else lg[j] = lo + int'($urandom_range(w - lo));
    end
    t = '{vocab_id: id,
          logit_0: LOGIT_W'(lg[0]), logit_1: LOGIT_W'(lg[1]),
          logit_2: LOGIT_W'(lg[2]), logit_3: LOGIT_W'(lg[3]),
          logit_4: LOGIT_W'(lg[4]), logit_5: LOGIT_W'(lg[5]),
          logit_6: LOGIT_W'(lg[6]), logit_7: LOGIT_W'(lg[7]),
          last_token: last};
    return t;
  endfunction

  // Directed item with three live classes; upper lanes held at the top
  // value so that a wrong class count shows up.
  function automatic tok_t tok3(int id, int l0, int l1, int l2, bit last);
    tok_t t;
    t            = '0;
    t.vocab_id   = ID_W'(id);
    t.logit_0    = LOGIT_W'(l0);
    t.logit_1    = LOGIT_W'(l1);
    t.logit_2    = LOGIT_W'(l2);
    t.logit_3    = 16'h7FFF;
    t.logit_4    = 16'h7FFF;
    t.logit_5    = 16'h7FFF;
    t.logit_6    = 16'h7FFF;
    t.logit_7    = 16'h7FFF;
    t.last_token = last;
    return t;
  endfunction

  // Random gap, then hold the item until the block takes it.
  task automatic send_token(input tok_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      tok_valid <= 1'b0;
    end
    @(negedge clk);
    tok_valid <= 1'b1;
    tok       <= t;
    @(posedge clk);
    while (tok_stall) @(posedge clk);
  endtask

  task automatic send_sequence(input int len, input bit may_stop);
    logic [ID_W-1:0] id;
    for (int i = 0; i < len; i++) begin
      id = pick_id(may_stop);
      send_token(make_token(pick_class(), id, i == len - 1));
    end
  endtask

  // Drain all spans, then give items with no result time to finish.
  task automatic wait_idle();
    @(negedge clk);
    tok_valid <= 1'b0;
    while (pending_spans != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_config(input int cc, input int b, input int ins,
                              input int s1, input int s2);
    wait_idle();
    write_reg(REG_CLASS_COUNT, CFG_W'(cc));
    write_reg(REG_BEGIN_CLASS, CFG_W'(b));
    write_reg(REG_INSIDE_CLASS, CFG_W'(ins));
    write_reg(REG_SKIP_FIRST, CFG_W'(s1));
    write_reg(REG_SKIP_SECOND, CFG_W'(s2));
    cfg_count  = cc;
    cfg_begin  = b;
    cfg_inside = ins;
    cfg_skip1  = ID_W'(s1);
    cfg_skip2  = ID_W'(s2);
  endtask

  task automatic run_directed();
    // skip, begin/inside tie (begin wins), inside, class 0 closes at the top
    send_token(tok3(101, 500, 900, -4, 1'b0));
    send_token(tok3(5000, -100, 32767, 32767, 1'b0));
    send_token(tok3(65535, 0, 0, 32767, 1'b0));
    send_token(tok3(7, 32767, 32767, 32767, 1'b0));
    // span at the bottom of the score range; all-equal logits pick class 0
    send_token(tok3(8, -32768, -32767, -32767, 1'b0));
    send_token(tok3(9, -32768, -32768, -32767, 1'b0));
    send_token(tok3(10, -32768, -32768, -32768, 1'b0));
    // inside with nothing open, then begin closes a one-token span
    send_token(tok3(11, 0, 1, 5, 1'b0));
    send_token(tok3(12, 0, 9, 3, 1'b0));
    // separator, padding stops tagging, last flushes the still-open span
    send_token(tok3(102, 0, 0, 0, 1'b0));
    send_token(tok3(0, 0, 0, 0, 1'b0));
    send_token(tok3(13, 0, 9, 0, 1'b0));
    send_token(tok3(14, 0, 9, 0, 1'b1));
    // lone padding item that is also last: done marker only
    send_token(tok3(0, 0, 0, 0, 1'b1));
    // single begin as last, then begin+begin-last for three results
    send_token(tok3(20, 0, 100, 0, 1'b1));
    send_token(tok3(21, 0, 100, 0, 1'b0));
    send_token(tok3(22, 0, 100, 0, 1'b1));
    // mean of -1 and -2 truncates to -1; last item closes by class 0
    send_token(tok3(23, -5, -1, -9, 1'b0));
    send_token(tok3(24, -5, -9, -2, 1'b0));
    send_token(tok3(25, 3, -9, -2, 1'b1));
  endtask

  initial begin
    int len;
    int b;
    int block_items;
    rst            = 1'b1;
    tok_valid      = 1'b0;
    tok            = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_pct   = 31;
    sink_stall_pct = 79;
    cfg_count      = int'(CLASS_COUNT_RST);
    cfg_begin      = int'(BEGIN_CLASS_RST);
    cfg_inside     = int'(INSIDE_CLASS_RST);
    cfg_skip1      = SKIP_FIRST_RST;
    cfg_skip2      = SKIP_SECOND_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part runs on the reset register values.
    run_directed();

    // Three idle profiles; each one walks through several register settings.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin src_idle_pct = 31; sink_stall_pct = 79; end
        1: begin src_idle_pct = 79; sink_stall_pct = 31; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        case ((p * 4 + blk) % 6)
          // count below range, inside is class 0
          0: apply_config(0, 1, 0, $urandom_range(65535), $urandom_range(65535));
          // count above range, top classes, extreme skip ids
          1: apply_config(15, 7, 6, 0, 65535);
          // begin class out of reach
          2: apply_config(2, 3, 1, 101, 102);
          // begin equals inside
          3: begin
            b = $urandom_range(7);
            apply_config(8, b, b, $urandom_range(65535), $urandom_range(65535));
          end
          4: apply_config($urandom_range(15), $urandom_range(7), $urandom_range(7),
                          $urandom_range(65535), $urandom_range(65535));
          default: apply_config(3, 1, 2, 101, 102);
        endcase
        block_items = 0;
        while (block_items < BLOCK_ITEMS) begin
          len = $urandom_range(10, 1);
          send_sequence(len, 1'b1);
          block_items += len;
        end
      end
    end

    wait_idle();
    if (check_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
